// ----- src/mrc_pkg.sv -----
// Shared types and codes for the memory region carver.
// Depends on nothing; the top, the cell and the testbench import it.
package mrc_pkg;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_RESERVE = 2'd1,
    OP_READ    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] length;
  } region_t;

  typedef enum logic [1:0] {
    C_HOLD   = 2'd0,
    C_TAKE_L = 2'd1,
    C_TAKE_R = 2'd2,
    C_LOAD   = 2'd3
  } cell_op_t;

  // Per-cell control: what to take this cycle and from which load port.
  typedef struct packed {
    cell_op_t op;
    logic     sel_b;
  } cell_ctl_t;

endpackage

// ----- src/mrc_if.sv -----
// Valid/ready channels of the memory region carver.
// Depends on no other file; its widths match mrc_pkg by convention.
interface mrc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] span_start;
  logic [31:0] span_size;
  logic [3:0]  entry_index;
  modport source (output valid, opcode, span_start, span_size, entry_index, input ready);
  modport sink   (input valid, opcode, span_start, span_size, entry_index, output ready);
endinterface

interface mrc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] entry_start;
  logic [31:0] entry_size;
  logic [4:0]  region_total;
  logic [1:0]  status;
  modport source (output valid, entry_start, entry_size, region_total, status, input ready);
  modport sink   (input valid, entry_start, entry_size, region_total, status, output ready);
endinterface

// ----- src/memory_region_carver.sv -----
// Memory region carver top level: controller over a row of region cells.
// Depends on mrc_pkg, mrc_if (mrc_req_if, mrc_rsp_if) and mrc_cell.
//
// Usage: one request word on req (opcode, span_start, span_size, entry_index)
// gives exactly one response word on rsp (entry_start, entry_size,
// region_total, status). Add, read and the unused opcode answer in the cycle after acceptance.
// A reserve that fits takes three walks over the table: a count walk, a trim walk
// that deletes or trims regions, and a split walk that inserts right remainders
// by shifting the cells behind; one that overflows ends after the count walk.
// Requests are taken only while no reserve is in flight and the response
// register is free or emptied in the same cycle; a stalled receiver holds
// the response and so holds off the next request.
// Reset clears the region count and the response valid; cell contents are
// left as they are and only entries below the count are ever read.
// A reserve that would need more than MAX_REGIONS entries answers table full
// and leaves the table unchanged.
module memory_region_carver
  import mrc_pkg::*;
#(
  parameter int MAX_REGIONS = 16,
  parameter int PAGE_BITS   = 12
) (
  input logic     clk,
  input logic     rst,
  mrc_req_if.sink   req,
  mrc_rsp_if.source rsp
);

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = $clog2(MAX_REGIONS);
  localparam int NW = $clog2(2 * MAX_REGIONS + 1);
  localparam logic [33:0] PMASK = 34'((34'd1 << PAGE_BITS) - 34'd1);
  localparam logic [33:0] MASK32 = 34'h0_FFFF_FFFF;

  typedef enum logic [1:0] {S_IDLE, S_COUNT, S_TRIM, S_SPLIT} state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   ptr;
  logic [NW-1:0]   n;
  logic [33:0]     cut_lo;
  logic [33:0]     cut_hi;
  logic            ov;
  logic [31:0]     es;
  logic [31:0]     ez;
  logic [4:0]      rtot;
  status_t         st;

  region_t         cells [MAX_REGIONS];
  region_t         load_a;
  region_t         load_b;
  region_t         cur;
  logic [IW-1:0]   sel;

  logic            acc;
  logic [33:0]     lo, hi, cut_lo_next, cut_hi_next;
  logic            ovl, kl, kr, walk;
  logic [NW-1:0]   pieces;
  region_t         left_piece, right_piece;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && (!ov || rsp.ready);

  assign rsp.valid        = ov;
  assign rsp.entry_start  = es;
  assign rsp.entry_size   = ez;
  assign rsp.region_total = rtot;
  assign rsp.status       = st;

  assign sel = (state == S_IDLE) ? IW'(req.entry_index) : ptr[IW-1:0];
  assign cur = cells[sel];

  assign cut_lo_next = {2'b00, req.span_start} & ~PMASK;
  assign cut_hi_next = (cut_lo_next + {2'b00, req.span_size} + PMASK) & ~PMASK;

  // Classify the entry under the walk pointer against the aligned span.
  assign lo   = {2'b00, cur.base};
  assign hi   = lo + {2'b00, cur.length};
  assign ovl  = !(cut_hi <= lo || cut_lo >= hi);
  assign kl   = ovl && (cut_lo > lo);
  assign kr   = ovl && (cut_hi < hi) && (cut_hi <= MASK32);
  assign walk = (ptr < count);
  assign pieces = ovl ? (NW'(kl) + NW'(kr)) : NW'(1);

  assign left_piece.base    = cur.base;
  assign left_piece.length  = 32'(cut_lo - lo);
  assign right_piece.base   = cut_hi[31:0];
  assign right_piece.length = 32'(hi - cut_hi);

  always_comb begin
    if (state == S_IDLE) begin
      load_a.base   = req.span_start;
      load_a.length = req.span_size;
    end else if (state == S_TRIM && kr && !kl) begin
      load_a = right_piece;
    end else begin
      load_a = left_piece;
    end
  end
  assign load_b = right_piece;

  for (genvar j = 0; j < MAX_REGIONS; j++) begin : g_cell
    region_t   lnb, rnb;
    cell_ctl_t ctl;

    if (j == 0) begin : g_first
      assign lnb = cells[j];
    end else begin : g_left
      assign lnb = cells[j-1];
    end
    if (j == MAX_REGIONS - 1) begin : g_last
      assign rnb = cells[j];
    end else begin : g_right
      assign rnb = cells[j+1];
    end

    always_comb begin
      ctl.op    = C_HOLD;
      ctl.sel_b = 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc && req.opcode == OP_ADD && count < CW'(MAX_REGIONS)
              && CW'(j) == count) begin
            ctl.op = C_LOAD;
          end
        end
        S_TRIM: begin
          if (walk && ovl && !kl && !kr && CW'(j) >= ptr) begin
            ctl.op = C_TAKE_R;
          end else if (walk && (kl ^ kr) && CW'(j) == ptr) begin
            ctl.op = C_LOAD;
          end
        end
        S_SPLIT: begin
          if (walk && ovl) begin
            if (CW'(j) == ptr) begin
              ctl.op = C_LOAD;
            end else if (CW'(j) == ptr + CW'(1)) begin
              ctl.op    = C_LOAD;
              ctl.sel_b = 1'b1;
            end else if (CW'(j) > ptr + CW'(1)) begin
              ctl.op = C_TAKE_L;
            end
          end
        end
        default: ;
      endcase
    end

    mrc_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .left   (lnb),
      .right  (rnb),
      .load_a (load_a),
      .load_b (load_b),
      .entry  (cells[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ptr   <= '0;
      n     <= '0;
      ov    <= 1'b0;
    end else begin
      // drop the taken response unless a new one is loaded in the same cycle
      if (rsp.valid && rsp.ready && !(acc && req.opcode != OP_RESERVE)) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            st <= ST_OK;
            es <= '0;
            ez <= '0;
            rtot <= 5'(count);
            case (req.opcode)
              OP_ADD: begin
                ov <= 1'b1;
                if (count >= CW'(MAX_REGIONS)) begin
                  st <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                  rtot  <= 5'(count + CW'(1));
                end
              end
              OP_RESERVE: begin
                cut_lo <= cut_lo_next;
                cut_hi <= cut_hi_next;
                ptr    <= '0;
                n      <= '0;
                state  <= S_COUNT;
              end
              OP_READ: begin
                ov <= 1'b1;
                if (8'(req.entry_index) >= 8'(count)) begin
                  st <= ST_RANGE;
                end else begin
                  es <= cur.base;
                  ez <= cur.length;
                end
              end
              default: ov <= 1'b1;
            endcase
          end
        end
        S_COUNT: begin
          if (walk) begin
            n   <= n + pieces;
            ptr <= ptr + CW'(1);
          end else if (n > NW'(MAX_REGIONS)) begin
            st    <= ST_FULL;
            rtot  <= 5'(count);
            ov    <= 1'b1;
            state <= S_IDLE;
          end else begin
            ptr   <= '0;
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (walk) begin
            // drop a fully covered region in place; the pointer stays
            if (ovl && !kl && !kr) count <= count - CW'(1);
            else ptr <= ptr + CW'(1);
          end else begin
            ptr   <= '0;
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (walk) begin
            if (ovl) begin
              count <= count + CW'(1);
              ptr   <= ptr + CW'(2);
            end else begin
              ptr <= ptr + CW'(1);
            end
          end else begin
            st    <= ST_OK;
            rtot  <= 5'(count);
            ov    <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_REGIONS))
    else $error("region count above table size");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRIM || state == S_SPLIT) |-> ptr <= count)
    else $error("walk pointer past table end");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT && !walk && n > NW'(MAX_REGIONS)) |=> $stable(count))
    else $error("overflowing reserve changed the table");

  a_split_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT && walk && ovl) |-> count < CW'(MAX_REGIONS))
    else $error("split with no free cell");
`endif

endmodule

// ----- src/mrc_cell.sv -----
// One table cell: holds a region and takes a neighbor's or a loaded value.
// Depends on mrc_pkg.
module mrc_cell
  import mrc_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  region_t   left,
  input  region_t   right,
  input  region_t   load_a,
  input  region_t   load_b,
  output region_t   entry
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      C_TAKE_L: entry <= left;
      C_TAKE_R: entry <= right;
      C_LOAD:   entry <= ctl.sel_b ? load_b : load_a;
      default:  entry <= entry;
    endcase
  end

endmodule

// ----- sim/tb_memory_region_carver.sv -----
// Testbench for memory_region_carver: random and directed add, reserve and read words.
// Depends on mrc_pkg, mrc_if and the RTL top; predicts each response in a local table model.
module tb_memory_region_carver;
  import mrc_pkg::*;

  localparam int MAX_REGIONS = 16;
  localparam int PAGE_BITS   = 12;
  localparam logic [32:0] PAGE_MASK = (33'd1 << PAGE_BITS) - 33'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] span_start;
    logic [31:0] span_size;
    logic [3:0]  entry_index;
  } req_word_t;

  typedef struct packed {
    logic [31:0] entry_start;
    logic [31:0] entry_size;
    logic [4:0]  region_total;
    logic [1:0]  status;
  } rsp_word_t;

  logic clk;
  logic rst;

  mrc_req_if req ();
  mrc_rsp_if rsp ();

  memory_region_carver #(
    .MAX_REGIONS(MAX_REGIONS),
    .PAGE_BITS(PAGE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  req_word_t pending_words[$];
  rsp_word_t expected_rsps[$];
  int        fail_count;
  bit        feed_done;
  bit        hold_sender;

  // Predicted free-region table
  logic [31:0] tbl_base[MAX_REGIONS];
  logic [31:0] tbl_len[MAX_REGIONS];
  int          tbl_count;

  function automatic rsp_word_t predict_region_op(req_word_t w);
    rsp_word_t   r;
    logic [31:0] nb[2*MAX_REGIONS];
    logic [31:0] nl[2*MAX_REGIONS];
    int          n;
    logic [32:0] cut_lo, cut_hi, lo, hi;
    r = '0;
    r.status = ST_OK;
    case (w.opcode)
      OP_ADD: begin
        if (tbl_count >= MAX_REGIONS) r.status = ST_FULL;
        else begin
          tbl_base[tbl_count] = w.span_start;
          tbl_len[tbl_count]  = w.span_size;
          tbl_count++;
        end
      end
      OP_RESERVE: begin
        n = 0;
        cut_lo = {1'b0, w.span_start} & ~PAGE_MASK;
        // aligned end stays below 2^33, so 33 bits hold it
        cut_hi = (cut_lo + {1'b0, w.span_size} + PAGE_MASK) & ~PAGE_MASK;
        for (int i = 0; i < tbl_count; i++) begin
          lo = {1'b0, tbl_base[i]};
          hi = lo + {1'b0, tbl_len[i]};
          if (cut_hi <= lo || cut_lo >= hi) begin
            nb[n] = tbl_base[i]; nl[n] = tbl_len[i]; n++;
          end else begin
            if (cut_lo > lo) begin
              nb[n] = lo[31:0]; nl[n] = cut_lo[31:0] - lo[31:0]; n++;
            end
            if (cut_hi < hi && !cut_hi[32]) begin
              nb[n] = cut_hi[31:0]; nl[n] = hi[31:0] - cut_hi[31:0]; n++;
            end
          end
        end
        if (n > MAX_REGIONS) r.status = ST_FULL;
        else begin
          for (int i = 0; i < n; i++) begin
            tbl_base[i] = nb[i];
            tbl_len[i]  = nl[i];
          end
          tbl_count = n;
        end
      end
      OP_READ: begin
        if (w.entry_index >= tbl_count) r.status = ST_RANGE;
        else begin
          r.entry_start = tbl_base[w.entry_index];
          r.entry_size  = tbl_len[w.entry_index];
        end
      end
      default: ;
    endcase
    r.region_total = tbl_count[4:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: bursts with random gaps
  int gap_left;
  int burst_left;
  always @(posedge clk) begin
    if (rst) begin
      req.valid       <= 1'b0;
      req.opcode      <= OP_ADD;
      req.span_start  <= '0;
      req.span_size   <= '0;
      req.entry_index <= '0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(predict_region_op(pending_words.pop_front()));
      end
      if (!(req.valid && !req.ready)) begin
        if (gap_left > 0) gap_left--;
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
        if (pending_words.size() > 0 && gap_left == 0 && !hold_sender) begin
          req.valid       <= 1'b1;
          req.opcode      <= pending_words[0].opcode;
          req.span_start  <= pending_words[0].span_start;
          req.span_size   <= pending_words[0].span_size;
          req.entry_index <= pending_words[0].entry_index;
          if (burst_left > 0) burst_left--;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern and response check
  logic [7:0] stall_pattern;
  int         stall_phase;
  always @(posedge clk) begin
    rsp_word_t got, want;
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_phase = 0;
      stall_pattern = 8'hFF;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.entry_start, rsp.entry_size, rsp.region_total, rsp.status};
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with none expected: got %h", $time, got);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.entry_start !== want.entry_start)
            $display("%0t: entry_start exp %h got %h", $time, want.entry_start,
                     got.entry_start);
          if (got.entry_size !== want.entry_size)
            $display("%0t: entry_size exp %h got %h", $time, want.entry_size,
                     got.entry_size);
          if (got.region_total !== want.region_total)
            $display("%0t: region_total exp %0d got %0d", $time, want.region_total,
                     got.region_total);
          if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got !== want) fail_count++;
        end
      end
      stall_phase = (stall_phase + 1) % 8;
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 8'hFF;
          1: stall_pattern = 8'hAA;
          2: stall_pattern = 8'($urandom());
          default: stall_pattern = 8'h0F;
        endcase
      end
      rsp.ready <= stall_pattern[stall_phase];
    end
  end

  function automatic req_word_t make_word(logic [1:0] op, logic [31:0] s, logic [31:0] z,
                                          logic [3:0] idx);
    req_word_t w;
    w.opcode = op; w.span_start = s; w.span_size = z; w.entry_index = idx;
    return w;
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 15) << 28 | $urandom_range(0, 255) << 12;
      2: return 32'hFFFF_F000 | $urandom_range(0, 4095);
      default: return $urandom_range(0, 32'h000F_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 4096);
      2: return $urandom_range(0, 4096);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  initial begin
    logic [1:0] op;
    int roll;
    rst = 1'b1;
    fail_count = 0;
    feed_done = 1'b0;
    hold_sender = 1'b0;
    tbl_count = 0;
    // Directed: empty read, extremes, splits, wide ends, full table, unused opcode
    pending_words.push_back(make_word(OP_READ, 0, 0, 0));
    pending_words.push_back(make_word(OP_RESERVE, 32'h1000, 32'h1000, 0));
    pending_words.push_back(make_word(OP_ADD, 32'h0010_0000, 32'h0010_0000, 0));
    pending_words.push_back(make_word(OP_RESERVE, 32'h0014_0123, 32'h10, 0));
    pending_words.push_back(make_word(OP_ADD, 32'hFFFF_0000, 32'hFFFF_FFFF, 0));
    pending_words.push_back(make_word(OP_RESERVE, 32'hFFFF_8001, 32'h0000_8000, 0));
    pending_words.push_back(make_word(OP_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    pending_words.push_back(make_word(OP_READ, 0, 0, 4'd0));
    pending_words.push_back(make_word(OP_READ, 0, 0, 4'd1));
    pending_words.push_back(make_word(OP_READ, 0, 0, 4'd15));
    pending_words.push_back(make_word(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    for (int i = 0; i < 15; i++)
      pending_words.push_back(make_word(OP_ADD, i << 20, 32'h0008_0000, 0));
    pending_words.push_back(make_word(OP_ADD, 0, 0, 0));
    pending_words.push_back(make_word(OP_RESERVE, 32'h0020_0000, 32'h1000, 0));
    pending_words.push_back(make_word(OP_READ, 0, 0, 4'd15));
    pending_words.push_back(make_word(OP_RESERVE, 0, 32'hFFFF_FFFF, 0));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0);
    // Pause until everything is answered
    hold_sender = 1'b1;
    wait (expected_rsps.size() == 0);
    repeat (5) @(posedge clk);
    hold_sender = 1'b0;
    for (int k = 0; k < 700; k++) begin
      roll = $urandom_range(0, 9);
      op = (roll < 4) ? OP_ADD : (roll < 7) ? OP_RESERVE : (roll < 9) ? OP_READ : 2'd3;
      pending_words.push_back(make_word(op, pick_addr(), pick_size(), 4'($urandom())));
      if (k == 350) begin
        wait (pending_words.size() == 0);
        hold_sender = 1'b1;
        wait (expected_rsps.size() == 0);
        hold_sender = 1'b0;
      end
    end
    wait (pending_words.size() == 0);
    wait (expected_rsps.size() == 0);
    repeat (3 * MAX_REGIONS + 10) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end
endmodule
